[sv/assert_macros.svh]
// Assertion helper macros used by the accumulator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/bf16dp_pkg.sv]
// ----------------------------------------------------------------------------
// bf16dp_pkg
// Shared types and constants for the bfloat16 dot product accumulator.
// ----------------------------------------------------------------------------
package bf16dp_pkg;

  localparam int unsigned ExpW   = 8;
  localparam int unsigned ManW   = 7;
  localparam int unsigned GuardW = 8;
  // Significand with guard bits: hidden one, mantissa, guard bits.
  localparam int unsigned SigW   = 1 + ManW + GuardW;
  // One extra bit for the carry out of an effective addition.
  localparam int unsigned MagW   = SigW + 1;
  localparam int unsigned MaxAlign = 30;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;
  localparam logic [ExpW-1:0] ExpMax  = 8'd255;

  typedef logic [15:0] bf16_t;

endpackage

[sv/bf16_dot_product_accumulator_core.sv]
// ----------------------------------------------------------------------------
// bf16_dot_product_accumulator_core
// bfloat16 multiply-accumulate with emit-and-clear on the last pair.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o) carries one operand
// pair a_value_i, b_value_i and a last_i flag per transfer. Each pair is
// multiplied and the product is added into a bfloat16 running sum, all in
// combinational logic between the input ports and the accumulator register.
// When a transfer has last_i set, the updated sum is placed in the output
// register and offered on out_valid_o / dot_sum_o in the cycle after the
// input transfer; the running sum then starts again from +0.
// Throughput is one pair per cycle, limited by the single multiply and add
// path feeding the accumulator register, except while a last_i pair waits.
// If the receiver stalls with a result pending, pairs without last_i are
// still taken; a pair with last_i waits until the output register is free
// or is being drained in the same cycle.
// Reset clears the running sum to +0 and drops any pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bf16_dot_product_accumulator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bf16dp_pkg::bf16_t a_value_i,
  input  bf16dp_pkg::bf16_t b_value_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bf16dp_pkg::bf16_t dot_sum_o
);
  import bf16dp_pkg::*;

  bf16_t sum_q, sum_d, prod, acc;
  bf16_t out_q;
  logic  out_valid_q;
  logic  in_fire, out_free;

  // Single combinational pass: multiply, then add into the running sum.
  bf16dp_mul u_mul (.a_i(a_value_i), .b_i(b_value_i), .p_o(prod));
  bf16dp_add u_add (.a_i(sum_q), .b_i(prod), .s_o(acc));

  // The output slot is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !last_i || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    sum_d = sum_q;
    if (in_fire) begin
      sum_d = last_i ? '0 : acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      if (in_fire && last_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_i) begin
      out_q <= acc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = out_q;

  `ASSERT_CLK(a_last_sets_valid, in_fire && last_i |=> out_valid_o,
              "last transfer did not raise out_valid_o")
  `ASSERT_CLK(a_last_clears_sum, in_fire && last_i |=> sum_q == '0,
              "running sum not cleared after last transfer")
  `ASSERT_CLK(a_no_overwrite, out_valid_o && !out_ready_i |-> !(in_fire && last_i),
              "pending result overwritten")

endmodule

[sv/bf16dp_mul.sv]
// ----------------------------------------------------------------------------
// bf16dp_mul
// Combinational bfloat16 multiplier with truncation and exponent clamping.
// ----------------------------------------------------------------------------
module bf16dp_mul (
  input  bf16dp_pkg::bf16_t a_i,
  input  bf16dp_pkg::bf16_t b_i,
  output bf16dp_pkg::bf16_t p_o
);
  import bf16dp_pkg::*;

  logic [ExpW-1:0] ea, eb;
  logic [ManW-1:0] ma, mb, mant;
  logic            sr, zero;
  logic [15:0]     prod;
  logic signed [10:0] er;

  always_comb begin
    ea   = a_i[14:7];
    eb   = b_i[14:7];
    ma   = a_i[6:0];
    mb   = b_i[6:0];
    sr   = a_i[15] ^ b_i[15];
    zero = (a_i[14:0] == '0) || (b_i[14:0] == '0);
    prod = {8'd0, 1'b1, ma} * {8'd0, 1'b1, mb};
    er   = $signed({3'd0, ea}) + $signed({3'd0, eb}) - $signed({3'd0, ExpBias})
         + $signed({10'd0, prod[15]});
    mant = prod[15] ? prod[14:8] : prod[13:7];
    if (zero) begin
      p_o = '0;
    end else if (er < 0) begin
      p_o = {sr, 15'd0};
    end else if (er > 11'sd255) begin
      p_o = {sr, ExpMax, mant};
    end else begin
      p_o = {sr, er[7:0], mant};
    end
  end

endmodule

[sv/bf16dp_add.sv]
// ----------------------------------------------------------------------------
// bf16dp_add
// Combinational bfloat16 adder with eight guard bits and truncation.
// ----------------------------------------------------------------------------
module bf16dp_add (
  input  bf16dp_pkg::bf16_t a_i,
  input  bf16dp_pkg::bf16_t b_i,
  output bf16dp_pkg::bf16_t s_o
);
  import bf16dp_pkg::*;

  logic [ExpW-1:0] ea, eb, exp_r, dabs;
  logic [SigW-1:0] siga, sigb, sh;
  logic [MagW-1:0] mag, norm;
  logic            sa, sb, sign_r, a_big;
  logic [4:0]      lz;
  logic signed [9:0] exp_f;

  always_comb begin
    sa   = a_i[15];
    sb   = b_i[15];
    ea   = a_i[14:7];
    eb   = b_i[14:7];
    a_big = ea >= eb;
    dabs = a_big ? (ea - eb) : (eb - ea);
    exp_r = a_big ? ea : eb;
    sh   = a_big ? {1'b1, b_i[6:0], 8'd0} : {1'b1, a_i[6:0], 8'd0};
    sh   = (dabs > 8'(MaxAlign)) ? '0 : (sh >> dabs);
    siga = a_big ? {1'b1, a_i[6:0], 8'd0} : sh;
    sigb = a_big ? sh : {1'b1, b_i[6:0], 8'd0};
    if (sa == sb) begin
      mag = {1'b0, siga} + {1'b0, sigb};
      sign_r = sa;
    end else if (siga >= sigb) begin
      mag = {1'b0, siga - sigb};
      sign_r = sa;
    end else begin
      mag = {1'b0, sigb - siga};
      sign_r = sb;
    end
    // Leading zero count below the carry bit.
    lz = 5'd0;
    for (int i = 0; i < SigW; i++) begin
      if (mag[i]) lz = 5'(SigW - 1 - i);
    end
    if (mag[MagW-1]) begin
      norm  = mag >> 1;
      exp_f = $signed({2'd0, exp_r}) + 10'sd1;
    end else begin
      norm  = mag << lz;
      exp_f = $signed({2'd0, exp_r}) - $signed({5'd0, lz});
    end
    if (a_i[14:0] == '0) begin
      s_o = b_i;
    end else if (b_i[14:0] == '0) begin
      s_o = a_i;
    end else if (mag == '0) begin
      s_o = '0;
    end else if (exp_f < 0) begin
      s_o = {sign_r, 15'd0};
    end else if (exp_f > 10'sd255) begin
      s_o = {sign_r, ExpMax, norm[SigW-2 -: ManW]};
    end else begin
      s_o = {sign_r, exp_f[7:0], norm[SigW-2 -: ManW]};
    end
  end

endmodule

[bench/bf16_mac_checker.sv]
// ----------------------------------------------------------------------------
// bf16_mac_checker
// Watches both channels of the bfloat16 multiply-accumulate core, keeps its
// own running sum and compares every emitted dot product in order.
// ----------------------------------------------------------------------------
module bf16_mac_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bf16dp_pkg::bf16_t a_value_i,
  input  bf16dp_pkg::bf16_t b_value_i,
  input  logic              last_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bf16dp_pkg::bf16_t dot_sum_i,
  output int unsigned       fail_count_o,
  output int unsigned       sums_pending_o
);
  import bf16dp_pkg::*;

  bf16_t acc_sum;
  bf16_t sum_queue[$];

  function automatic bf16_t pred_pack(logic s, int e, logic [6:0] m);
    logic [7:0] e8;
    e8 = e[7:0];
    return {s, e8, m};
  endfunction

  function automatic bf16_t pred_mul(bf16_t a, bf16_t b);
    logic [15:0] prod;
    logic [6:0]  mant;
    int          er;
    if (a[14:0] == 15'd0 || b[14:0] == 15'd0) return 16'h0000;
    prod = {8'd0, 1'b1, a[6:0]} * {8'd0, 1'b1, b[6:0]};
    er = int'(a[14:7]) + int'(b[14:7]) - int'(ExpBias);
    if (prod[15]) begin
      mant = prod[14:8];
      er++;
    end else begin
      mant = prod[13:7];
    end
    if (er < 0) return pred_pack(a[15] ^ b[15], 0, 7'd0);
    if (er > int'(ExpMax)) er = int'(ExpMax);
    return pred_pack(a[15] ^ b[15], er, mant);
  endfunction

  function automatic bf16_t pred_add(bf16_t a, bf16_t b);
    logic [31:0] sa, sb, mag;
    logic        sign_r;
    int          diff, exp_r, sh;
    if (a[14:0] == 15'd0) return b;
    if (b[14:0] == 15'd0) return a;
    sa = {1'b1, a[6:0]} << GuardW;
    sb = {1'b1, b[6:0]} << GuardW;
    diff = int'(a[14:7]) - int'(b[14:7]);
    sh = 0;
    if (diff >= 0) begin
      exp_r = a[14:7];
      sb = (diff > MaxAlign) ? 32'd0 : sb >> diff;
    end else begin
      exp_r = b[14:7];
      sa = (-diff > MaxAlign) ? 32'd0 : sa >> (-diff);
    end
    if (a[15] == b[15]) begin
      mag = sa + sb;
      sign_r = a[15];
    end else if (sa >= sb) begin
      mag = sa - sb;
      sign_r = a[15];
    end else begin
      mag = sb - sa;
      sign_r = b[15];
    end
    if (mag == 0) return 16'h0000;
    while (mag >= 32'h10000) begin
      mag >>= 1;
      sh++;
    end
    while (mag < 32'h8000) begin
      mag <<= 1;
      sh--;
    end
    exp_r += sh;
    if (exp_r < 0) return pred_pack(sign_r, 0, 7'd0);
    if (exp_r > int'(ExpMax)) exp_r = int'(ExpMax);
    return pred_pack(sign_r, exp_r, mag[14:8]);
  endfunction

  assign sums_pending_o = sum_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bf16_t nxt;
    if (!rst_ni) begin
      acc_sum = 16'h0000;
      sum_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected dot_sum expected none actual %h", $time, dot_sum_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          nxt = sum_queue.pop_front();
          if (nxt !== dot_sum_i) begin
            $display("%0t: dot_sum expected %h actual %h", $time, nxt, dot_sum_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        acc_sum = pred_add(acc_sum, pred_mul(a_value_i, b_value_i));
        if (last_i) begin
          sum_queue.push_back(acc_sum);
          acc_sum = 16'h0000;
        end
      end
    end
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives operand pairs into the bfloat16 dot product core with random gaps
// and output stalls; the checker predicts each sum and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import bf16dp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  bf16_t       a_value_i = '0;
  bf16_t       b_value_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  bf16_t       dot_sum_o;
  int unsigned fail_count;
  int unsigned sums_pending;
  // While set, neither side inserts idle cycles.
  logic        no_idle = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bf16_dot_product_accumulator_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .a_value_i, .b_value_i, .last_i,
    .out_valid_o, .out_ready_i, .dot_sum_o
  );

  bf16_mac_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .a_value_i, .b_value_i,
    .last_i, .out_valid_i(out_valid_o), .out_ready_i, .dot_sum_i(dot_sum_o),
    .fail_count_o(fail_count), .sums_pending_o(sums_pending)
  );

  // The receiver stalls with a probability of 29 in a hundred unless idling is off.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 29);
  end

  // Random operand with a bias toward zeros, extreme exponents and close
  // exponents, so that underflow, clamping and cancellation all show up.
  function automatic bf16_t pick_operand();
    logic [7:0] e;
    case ($urandom_range(9))
      0: return {1'($urandom_range(1)), 15'd0};
      1: e = $urandom_range(1) ? 8'd0 : 8'd255;
      2: e = 8'($urandom_range(20));
      3: e = 8'd235 + 8'($urandom_range(20));
      default: e = 8'd112 + 8'($urandom_range(30));
    endcase
    return {1'(($urandom_range(1))), e, 7'($urandom())};
  endfunction

  // One transfer: valid is held with a steady payload until it is taken.
  // An idle gap may come first; the next item follows without dropping valid.
  task automatic send_pair(bf16_t a, bf16_t b, logic lst);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_value_i  <= a;
    b_value_i  <= b;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    int len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros of both signs, extreme exponents, overflow clamp,
    // product underflow, exact cancellation and a wide alignment shift.
    send_pair(16'h0000, 16'h3F80, 1'b1);
    send_pair(16'h8000, 16'hBF80, 1'b1);
    send_pair(16'h0001, 16'h0001, 1'b1);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'hFFFF, 16'h7FFF, 1'b1);
    send_pair(16'h0080, 16'h0080, 1'b1);
    send_pair(16'h3F80, 16'h3F80, 1'b0);
    send_pair(16'hBF80, 16'h3F80, 1'b1);
    send_pair(16'h7F00, 16'h3F80, 1'b0);
    send_pair(16'h0080, 16'h3F80, 1'b1);
    send_pair(16'h3FC0, 16'h3FC0, 1'b0);
    send_pair(16'h3F80, 16'h4000, 1'b0);
    send_pair(16'hC040, 16'h3F80, 1'b1);
    send_pair(16'h4000, 16'hC000, 1'b1);
    send_pair(16'h7F80, 16'h4000, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);

    // Random dot products of mostly short lengths; one stretch without idling.
    for (int n = 0; n < 1100; n += len) begin
      no_idle <= (n >= 500 && n < 650);
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
      for (int k = 0; k < len; k++)
        send_pair(pick_operand(), pick_operand(), k == len - 1);
    end
    in_valid_i <= 1'b0;
    no_idle <= 1'b0;

    // Let the checker record the final transfer before looking at its queue.
    @(posedge clk_i);
    while (sums_pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/bf16dp_pkg.sv
sv/bf16dp_mul.sv
sv/bf16dp_add.sv
sv/bf16_dot_product_accumulator_core.sv
bench/bf16_mac_checker.sv
bench/tb_top.sv
